// File: rtl/core/sra_pkg.sv
package sra_pkg;

  // Fixed field widths
  localparam int SLOT_W    = 4;
  localparam int BYTE_W    = 8;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int S_DATA_W  = 16;
  localparam int M_DATA_W  = 16;

  // Register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [BYTE_W-1:0]    END_CODE_RESET = 8'd26;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE = 1'b1;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_ACK   = 2'd1,
    OP_NAK   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REFUSE = 2'd1,
    KIND_SEND   = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic do_offer;
    logic do_ack;
    logic load_nak;
    logic tick_start;
    logic nak_send;
    logic scan_step;
    logic flush_pend;
    logic emit_done;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic sn_ok;
    logic need_send;
    logic scan_end;
    logic all_done;
    logic out_free;
    logic pend_valid;
  } status_t;

endpackage

// File: rtl/core/sra_ram.sv
module sra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/sra_ctrl.sv
module sra_ctrl import sra_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NAK_RD,
    ST_NAK_SEND,
    ST_SCAN_RD,
    ST_SCAN_EVAL,
    ST_FLUSH,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  // Sequence one item through the datapath
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.op)
          OP_OFFER: begin
            if (sts.out_free) begin
              cmd.do_offer = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          OP_ACK: begin
            cmd.do_ack = 1'b1;
            state_next = ST_IDLE;
          end
          OP_NAK: begin
            if (sts.sn_ok) begin
              cmd.load_nak = 1'b1;
              state_next   = ST_NAK_RD;
            end else begin
              state_next = ST_IDLE;
            end
          end
          OP_TICK: begin
            cmd.tick_start = 1'b1;
            state_next     = ST_SCAN_RD;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_NAK_RD: begin
        state_next = ST_NAK_SEND;
      end
      ST_NAK_SEND: begin
        if (sts.out_free) begin
          cmd.nak_send = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_next = sts.scan_end ? ST_FLUSH : ST_SCAN_EVAL;
      end
      ST_SCAN_EVAL: begin
        // a send with a result already held pushes that one out first
        if (!(sts.need_send && sts.pend_valid) || sts.out_free) begin
          cmd.scan_step = 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_FLUSH: begin
        if (sts.pend_valid) begin
          if (sts.out_free) begin
            cmd.flush_pend = 1'b1;
            state_next     = sts.all_done ? ST_DONE : ST_IDLE;
          end
        end else begin
          state_next = sts.all_done ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/sra_dp.sv
module sra_dp import sra_pkg::*; #(
  parameter int SLOTS     = 10,
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [S_DATA_W-1:0]  s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 s_tlast,
  input  cmd_t                 cmd,
  output status_t              sts,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  localparam int IW   = $clog2(SLOTS);
  localparam int FW   = $clog2(SLOTS + 1);
  localparam int HALF = SLOTS / 2;
  localparam int CW   = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // Captured item
  op_t               op_q;
  logic [BYTE_W-1:0] byte_q;
  logic              eod_q;
  logic [SLOT_W-1:0] sn_q;

  // Configuration
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [BYTE_W-1:0]    end_code_q;

  // Window state
  logic [SLOTS-1:0]     acked;
  logic [SLOTS-1:0]     sent;
  logic [IW-1:0]        front;
  logic [IW-1:0]        rear;
  logic [IW-1:0]        cur;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        steps;
  logic [FW-1:0]        k;
  logic [TIME_BITS-1:0] clock;
  logic                 closed;
  logic                 at_front;

  // Held send result of a scan
  logic              pend_valid;
  logic [IW-1:0]     pend_slot;
  logic [BYTE_W-1:0] pend_byte;

  // Output register
  logic              out_valid;
  kind_t             out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  // Memory ports
  logic [BYTE_W-1:0]    pay_rdata;
  logic [TIME_BITS-1:0] st_rdata;
  logic                 pay_we;
  logic                 st_we;
  logic [BYTE_W-1:0]    pay_wdata;

  // Decode and status
  logic [IW-1:0]        sn_idx;
  logic                 sn_ok;
  logic                 refuse;
  logic                 all_done;
  logic                 out_free;
  logic [TIME_BITS-1:0] age;
  logic                 need_send;

  // Result selection
  logic              emit;
  kind_t             e_kind;
  logic [SLOT_W-1:0] e_slot;
  logic [BYTE_W-1:0] e_byte;
  logic              e_last;

  assign sn_idx    = IW'(sn_q);
  assign sn_ok     = 32'(sn_q) < 32'(SLOTS);
  assign refuse    = closed || (fill > FW'(HALF));
  assign all_done  = closed && (fill == '0);
  assign out_free  = !out_valid || m_tready;
  assign age       = clock - st_rdata;
  assign need_send = !acked[cur] && (!sent[cur] || (CW'(age) > CW'(timeout_q)));

  assign sts.op         = op_q;
  assign sts.sn_ok      = sn_ok;
  assign sts.need_send  = need_send;
  assign sts.scan_end   = (k == steps);
  assign sts.all_done   = all_done;
  assign sts.out_free   = out_free;
  assign sts.pend_valid = pend_valid;

  assign pay_we    = cmd.do_offer && !refuse;
  assign pay_wdata = eod_q ? end_code_q : byte_q;
  assign st_we     = cmd.nak_send || (cmd.scan_step && need_send);

  sra_ram #(.WIDTH(BYTE_W), .DEPTH(SLOTS)) u_payload (
    .clk   (clk),
    .we    (pay_we),
    .waddr (rear),
    .wdata (pay_wdata),
    .raddr (cur),
    .rdata (pay_rdata)
  );

  sra_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_start (
    .clk   (clk),
    .we    (st_we),
    .waddr (cur),
    .wdata (clock),
    .raddr (cur),
    .rdata (st_rdata)
  );

  // Pick the result loaded into the output register
  always_comb begin
    emit   = 1'b0;
    e_kind = KIND_ACCEPT;
    e_slot = '0;
    e_byte = '0;
    e_last = 1'b1;
    if (cmd.do_offer) begin
      emit   = 1'b1;
      e_kind = refuse ? KIND_REFUSE : KIND_ACCEPT;
    end else if (cmd.nak_send) begin
      emit   = 1'b1;
      e_kind = KIND_SEND;
      e_slot = SLOT_W'(cur);
      e_byte = pay_rdata;
    end else if (cmd.scan_step && need_send && pend_valid) begin
      emit   = 1'b1;
      e_kind = KIND_SEND;
      e_slot = SLOT_W'(pend_slot);
      e_byte = pend_byte;
      e_last = 1'b0;
    end else if (cmd.flush_pend) begin
      emit   = 1'b1;
      e_kind = KIND_SEND;
      e_slot = SLOT_W'(pend_slot);
      e_byte = pend_byte;
      e_last = !all_done;
    end else if (cmd.emit_done) begin
      emit   = 1'b1;
      e_kind = KIND_DONE;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_q  <= TIMEOUT_RESET;
      end_code_q <= END_CODE_RESET;
      acked      <= '0;
      sent       <= '0;
      front      <= '0;
      rear       <= '0;
      cur        <= '0;
      fill       <= '0;
      steps      <= '0;
      k          <= '0;
      clock      <= '0;
      closed     <= 1'b0;
      at_front   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_TIMEOUT:  timeout_q  <= cfg_data[TIMEOUT_W-1:0];
          REG_END_CODE: end_code_q <= cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end

      // append a byte at the rear
      if (cmd.do_offer && !refuse) begin
        acked[rear] <= 1'b0;
        sent[rear]  <= 1'b0;
        rear        <= next_idx(rear);
        fill        <= fill + 1'b1;
        if (eod_q) begin
          closed <= 1'b1;
        end
      end

      if (cmd.do_ack && sn_ok) begin
        acked[sn_idx] <= 1'b1;
      end

      if (cmd.load_nak) begin
        cur <= sn_idx;
      end

      if (cmd.nak_send) begin
        sent[cur] <= 1'b1;
      end

      // start a scan from the front
      if (cmd.tick_start) begin
        clock    <= clock + 1'b1;
        cur      <= front;
        steps    <= fill;
        k        <= '0;
        at_front <= 1'b1;
      end

      // one slot of the scan
      if (cmd.scan_step) begin
        if (!acked[cur]) begin
          at_front <= 1'b0;
          if (need_send) begin
            sent[cur]  <= 1'b1;
            pend_valid <= 1'b1;
          end
        end else if (at_front) begin
          front <= next_idx(cur);
          fill  <= fill - 1'b1;
        end
        cur <= next_idx(cur);
        k   <= k + 1'b1;
      end

      if (cmd.flush_pend) begin
        pend_valid <= 1'b0;
      end

      // output register: load or drain
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(s_tuser);
      byte_q <= s_tdata[BYTE_W-1:0];
      sn_q   <= s_tdata[BYTE_W +: SLOT_W];
      eod_q  <= s_tlast;
    end
    if (cmd.scan_step && need_send) begin
      pend_slot <= cur;
      pend_byte <= pay_rdata;
    end
    if (emit) begin
      out_kind <= e_kind;
      out_slot <= e_slot;
      out_byte <= e_byte;
      out_last <= e_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_DATA_W - SLOT_W - BYTE_W)'(0), out_byte, out_slot};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // Window occupancy never passes the offer limit plus one
  assert property (@(posedge clk) disable iff (rst) fill <= FW'(HALF + 1))
    else $error("window fill above limit");

  // An empty window has front and rear together
  assert property (@(posedge clk) disable iff (rst) (fill == '0) |-> (front == rear))
    else $error("empty window with front and rear apart");

  // Closed input stays closed until reset
  assert property (@(posedge clk) disable iff (rst) closed |=> closed)
    else $error("input reopened");

endmodule

// File: rtl/core/selective_repeat_arq_sender.sv
// Channel  Signals                                  Carries
// -------  ---------------------------------------  ---------------------------------------
// s        s_tvalid s_tready s_tdata s_tuser s_tlast  operation, data byte, slot no, end flag
// m        m_tvalid m_tready m_tdata m_tuser m_tlast  kind, frame slot, frame byte, last
// cfg      cfg_valid cfg_ready cfg_index cfg_data   0 timeout_ticks, 1 end_code
//
// Offer and ack pass through capture and decode; a nak also reads the payload before its send.
// A tick scans each live window slot, then closes out; every slot is one memory read and one check.
// Reset clears the window, the tick clock and the registers to their defaults.
// A result waits in the output register; the next item is taken meanwhile,
// and a further result stalls the sequencer until the register drains.
module selective_repeat_arq_sender import sra_pkg::*; #(
  parameter int SLOTS     = 10,
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // [7:0] data_byte, [11:8] slot_no, zero pad
  input  logic [1:0]           s_tuser,   // [1:0] operation
  input  logic                 s_tlast,   // end_of_data
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [3:0] frame_slot, [11:4] frame_byte, zero pad
  output logic [1:0]           m_tuser,   // [1:0] kind
  output logic                 m_tlast,   // last
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  sra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sra_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sra_pkg::*;

  localparam int SLOT_COUNT    = 10;
  localparam int SETTLE_CYCLES = 50;
  localparam int STALL_LIMIT   = 5000;

  // One frame-side item as the block should produce it
  typedef struct {
    kind_t          kind;
    logic [3:0]     slot;
    logic [7:0]     data;
    logic           last;
  } frame_rec_t;

  // Window state of the sender plus the queue of frames still owed by the block
  class arq_window;
    logic [7:0]  payload [SLOT_COUNT];
    bit          acked [SLOT_COUNT];
    bit          sent [SLOT_COUNT];
    bit          written [SLOT_COUNT];
    logic [15:0] start_time [SLOT_COUNT];
    int unsigned front;
    int unsigned rear;
    int unsigned fill;
    logic [15:0] clock;
    bit          closed;
    logic [15:0] timeout;
    logic [7:0]  end_code;
    frame_rec_t  expected_frames [$];
    int unsigned error_count;

    function new();
      foreach (acked[i]) begin
        acked[i] = 1'b0;
        sent[i] = 1'b0;
        written[i] = 1'b0;
        payload[i] = '0;
        start_time[i] = '0;
      end
      front = 0;
      rear = 0;
      fill = 0;
      clock = '0;
      closed = 1'b0;
      timeout = TIMEOUT_RESET;
      end_code = END_CODE_RESET;
      error_count = 0;
    endfunction

    function int unsigned window_slot(int unsigned k);
      return (front + k) % SLOT_COUNT;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_TIMEOUT: begin
          timeout = val;
        end
        REG_END_CODE: begin
          end_code = val[7:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void queue_frame(kind_t kind, logic [3:0] slot, logic [7:0] data);
      frame_rec_t f;
      f.kind = kind;
      f.slot = slot;
      f.data = data;
      f.last = 1'b0;
      expected_frames.push_back(f);
    endfunction

    function void send_slot(int unsigned s);
      start_time[s] = clock;
      sent[s] = 1'b1;
      queue_frame(KIND_SEND, s[3:0], payload[s]);
    endfunction

    // Advance the window for one accepted input item and queue its frames
    function void take_item(op_t op, logic [7:0] b, logic eod, logic [3:0] sn);
      int unsigned before_cnt;
      int unsigned i;
      int unsigned steps;
      bit at_front;
      logic [15:0] age;
      before_cnt = expected_frames.size();
      case (op)
        OP_OFFER: begin
          if (closed || fill > SLOT_COUNT / 2) begin
            queue_frame(KIND_REFUSE, '0, '0);
          end else begin
            payload[rear] = eod ? end_code : b;
            acked[rear] = 1'b0;
            sent[rear] = 1'b0;
            written[rear] = 1'b1;
            rear = (rear + 1) % SLOT_COUNT;
            fill++;
            if (eod) closed = 1'b1;
            queue_frame(KIND_ACCEPT, '0, '0);
          end
        end
        OP_ACK: begin
          if (sn < SLOT_COUNT) acked[sn] = 1'b1;
        end
        OP_NAK: begin
          if (sn < SLOT_COUNT) send_slot(int'(sn));
        end
        default: begin
          // Scan front to rear: send new or stale slots, slide over acked front slots
          i = front;
          steps = fill;
          at_front = 1'b1;
          clock = clock + 16'd1;
          for (int k = 0; k < steps; k++) begin
            if (!acked[i]) begin
              age = clock - start_time[i];
              at_front = 1'b0;
              if (!sent[i] || age > timeout) send_slot(i);
            end else if (at_front) begin
              front = (i + 1) % SLOT_COUNT;
              fill--;
            end
            i = (i + 1) % SLOT_COUNT;
          end
          if (closed && fill == 0) queue_frame(KIND_DONE, '0, '0);
        end
      endcase
      if (expected_frames.size() > before_cnt)
        expected_frames[expected_frames.size() - 1].last = 1'b1;
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        error_count++;
      end
    endfunction

    // Match one accepted frame against the oldest one owed
    function void check_output(logic [1:0] kind, logic [3:0] slot, logic [7:0] data,
                               logic last);
      frame_rec_t f;
      if (expected_frames.size() == 0) begin
        $error("unexpected frame: kind %0d slot %0d byte %0d", kind, slot, data);
        error_count++;
      end else begin
        f = expected_frames.pop_front();
        compare("kind", 8'(f.kind), 8'(kind));
        compare("frame_slot", 8'(f.slot), 8'(slot));
        compare("frame_byte", f.data, data);
        compare("last", 8'(f.last), 8'(last));
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int unsigned snd_idle = 25;
  int unsigned rcv_idle = 57;
  int unsigned quiet_cycles = 0;

  arq_window book = new();

  selective_repeat_arq_sender #(
    .SLOTS     (SLOT_COUNT),
    .TIME_BITS (16)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the frame side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // Check every accepted frame
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      book.check_output(m_tuser, m_tdata[3:0], m_tdata[11:4], m_tlast);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Write both registers back to back; starts and ends at a falling edge
  task automatic write_regs(logic [15:0] timeout_val, logic [7:0] code_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_data <= timeout_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_reg(REG_TIMEOUT, timeout_val);
    @(negedge clk);
    cfg_index <= REG_END_CODE;
    cfg_data <= {8'd0, code_val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_reg(REG_END_CODE, {8'd0, code_val});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one input item, idling first at random; valid stays high on return
  task automatic send_item(op_t op, logic [7:0] b, logic eod, logic [3:0] sn);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'd0, sn, b};
    s_tlast <= eod;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.take_item(op, b, eod, sn);
    @(negedge clk);
  endtask

  // Hold input until every owed frame has come, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (book.expected_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Ack every live slot, then tick so the front slides over all of them
  task automatic empty_window();
    int unsigned n;
    n = book.fill;
    for (int k = 0; k < n; k++)
      send_item(OP_ACK, 8'($urandom), 1'($urandom_range(1)), 4'(book.window_slot(k)));
    if (n != 0) send_item(OP_TICK, 8'($urandom), 1'($urandom_range(1)), 4'($urandom));
  endtask

  // Mostly well-formed traffic: acks and naks aimed at the window, some noise
  task automatic random_item();
    int unsigned r;
    op_t op;
    logic [3:0] sn;
    logic [7:0] b;
    logic eod;
    r = $urandom_range(99);
    b = 8'($urandom);
    sn = 4'($urandom);
    eod = 1'($urandom_range(1));
    if (r < 35) begin
      op = OP_OFFER;
      eod = 1'b0;
    end else if (r < 60) begin
      op = OP_ACK;
      if (book.fill > 0 && $urandom_range(99) < 85)
        sn = 4'(book.window_slot($urandom_range(book.fill - 1)));
    end else if (r < 70) begin
      op = OP_NAK;
      if (book.fill > 0 && $urandom_range(99) < 75)
        sn = 4'(book.window_slot($urandom_range(book.fill - 1)));
      else if (sn < SLOT_COUNT && !book.written[sn])
        sn = 4'($urandom_range(15, SLOT_COUNT));
    end else begin
      op = OP_TICK;
    end
    send_item(op, b, eod, sn);
  endtask

  initial begin
    int unsigned end_slot;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily
    write_regs(16'd3, 8'd0);
    send_item(OP_OFFER, 8'h00, 1'b0, 4'd0);
    send_item(OP_OFFER, 8'hFF, 1'b0, 4'd15);
    send_item(OP_OFFER, 8'h5A, 1'b0, 4'd5);
    send_item(OP_OFFER, 8'hA5, 1'b0, 4'd10);
    send_item(OP_OFFER, 8'h01, 1'b0, 4'd3);
    send_item(OP_OFFER, 8'h80, 1'b0, 4'd7);
    // Window full: refuse
    send_item(OP_OFFER, 8'h33, 1'b0, 4'd0);
    send_item(OP_TICK, 8'hFF, 1'b1, 4'd15);
    send_item(OP_ACK, 8'h00, 1'b1, 4'd0);
    // Out-of-range frame numbers are dropped
    send_item(OP_ACK, 8'hFF, 1'b0, 4'd15);
    send_item(OP_NAK, 8'h12, 1'b1, 4'd12);
    send_item(OP_NAK, 8'h00, 1'b0, 4'd3);
    send_item(OP_ACK, 8'h00, 1'b0, 4'd1);
    send_item(OP_TICK, 8'h00, 1'b0, 4'd0);
    // Ack behind an unacked slot: front must not slide past it
    send_item(OP_ACK, 8'h00, 1'b1, 4'd4);
    send_item(OP_TICK, 8'h00, 1'b0, 4'd0);
    send_item(OP_TICK, 8'h00, 1'b1, 4'd0);
    send_item(OP_TICK, 8'h00, 1'b0, 4'd0);
    // Ack ahead of the window, cleared when the slot is appended
    send_item(OP_ACK, 8'h00, 1'b0, 4'd7);
    // Nak of a slot that already left the window
    send_item(OP_NAK, 8'h00, 1'b0, 4'd0);
    send_item(OP_OFFER, 8'h77, 1'b0, 4'd0);
    send_item(OP_OFFER, 8'hC3, 1'b0, 4'd0);
    send_item(OP_TICK, 8'h00, 1'b0, 4'd0);
    repeat (25) random_item();
    drain();

    // Sender idles heavily, receiver lightly
    snd_idle = 57;
    rcv_idle = 25;
    write_regs(16'd1, 8'd255);
    repeat (25) random_item();
    drain();

    // No idling from here on
    snd_idle = 0;
    rcv_idle = 0;
    write_regs(16'd2, 8'd255);
    empty_window();
    // Send once, then resend after the timeout
    send_item(OP_OFFER, 8'h3C, 1'b0, 4'd0);
    repeat (4) send_item(OP_TICK, 8'h00, 1'b0, 4'd0);
    repeat (15) random_item();
    drain();

    write_regs(16'd65535, 8'($urandom_range(255)));
    repeat (20) random_item();

    // Close input and run the window dry
    empty_window();
    end_slot = book.rear;
    send_item(OP_OFFER, 8'($urandom), 1'b1, 4'($urandom));
    send_item(OP_OFFER, 8'($urandom), 1'($urandom_range(1)), 4'($urandom));
    send_item(OP_TICK, 8'($urandom), 1'($urandom_range(1)), 4'($urandom));
    send_item(OP_NAK, 8'($urandom), 1'($urandom_range(1)), 4'(end_slot));
    empty_window();
    send_item(OP_TICK, 8'($urandom), 1'($urandom_range(1)), 4'($urandom));
    drain();

    if (book.error_count == 0 && book.expected_frames.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
